>>> rtl/pls_pkg.sv
// shared types and constants for the positional list store
// no dependencies
`default_nettype none

package pls_pkg;

	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_INSERT = 2'd1,
		OP_ERASE  = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// update command from the decode logic to the cell row
	typedef struct packed {
		logic             ins;
		logic             ers;
		logic             wr;
		logic [POS_W-1:0] pos;
	} upd_t;

endpackage

`default_nettype wire

>>> rtl/pls_store.sv
// row of data cells with fill count; each cell shifts, loads or holds
// depends on pls_pkg
`default_nettype none

module pls_store #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pls_pkg::upd_t                 upd,
	input  wire logic [DATA_WIDTH-1:0]         word,
	output logic      [DATA_WIDTH-1:0]         rd_data,
	output logic      [$clog2(DEPTH+1)-1:0]    cnt
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

	logic [DATA_WIDTH-1:0] cell_q [DEPTH];
	logic [CNT_W-1:0]      cnt_q;
	logic [CMP_W-1:0]      pos_c;
	logic [IDX_W-1:0]      rd_idx;

	assign pos_c   = CMP_W'(upd.pos);
	assign rd_idx  = IDX_W'(upd.pos);
	assign rd_data = cell_q[rd_idx];
	assign cnt     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (upd.ins) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (upd.ers) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		localparam int KP = (k > 0) ? k - 1 : 0;
		localparam int KN = (k < DEPTH - 1) ? k + 1 : k;
		localparam logic [CMP_W-1:0] KC = CMP_W'(k);

		always_ff @(posedge clk) begin
			if ((upd.ins || upd.wr) && pos_c == KC) begin
				cell_q[k] <= word;
			end else if (upd.ins && KC > pos_c) begin
				cell_q[k] <= cell_q[KP];
			end else if (upd.ers && KC >= pos_c && k < DEPTH - 1) begin
				cell_q[k] <= cell_q[KN];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/positional_list_store.sv
// top level of the positional list store: request register, decode, result register
// depends on pls_pkg and pls_store
//
// Ordered list of up to DEPTH words (DEPTH from 2 to 31, DATA_WIDTH from 1 to 32) with
// read, insert, erase and set at a position from the front. One request per clock is
// sustained while the receiver takes each result: a request is captured in the input
// register, decoded against the list and count while every cell shifts, loads or holds
// in parallel, and its result lands in the output register. Out-of-range positions return
// status 1 and an insert into a full list returns status 2; neither changes the list. The
// list comes out of reset empty with no clearing pass.
`default_nettype none

module positional_list_store #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire logic [1:0]                      operation,
	input  wire logic [pls_pkg::POS_W-1:0]       position,
	input  wire logic [pls_pkg::VALUE_W-1:0]     value,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output logic      [pls_pkg::VALUE_W-1:0]     result_value,
	output logic      [pls_pkg::STATUS_W-1:0]    status,
	output logic      [pls_pkg::COUNT_W-1:0]     count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

	logic                          valid_s1;
	pls_pkg::op_t                  op_s1;
	logic [pls_pkg::POS_W-1:0]     pos_s1;
	logic [DATA_WIDTH-1:0]         word_s1;

	logic                          valid_s2;
	logic [pls_pkg::VALUE_W-1:0]   result_value_s2;
	pls_pkg::status_t              status_s2;
	logic [pls_pkg::COUNT_W-1:0]   count_s2;

	logic                          advance;
	logic [DATA_WIDTH-1:0]         rd_data;
	logic [CNT_W-1:0]              cnt;
	logic [CNT_W-1:0]              cnt_nx;
	logic [CMP_W-1:0]              pos_c;
	logic [CMP_W-1:0]              cnt_c;
	logic                          in_range;
	logic                          ins_range;
	logic                          full;
	logic                          ins_ok;
	logic                          ers_ok;
	logic                          wr_ok;
	pls_pkg::status_t              st_c;
	logic [pls_pkg::VALUE_W-1:0]   res_c;
	pls_pkg::upd_t                 upd;

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_s1   <= pls_pkg::op_t'(operation);
			pos_s1  <= position;
			word_s1 <= DATA_WIDTH'(value);
		end
	end

	assign pos_c     = CMP_W'(pos_s1);
	assign cnt_c     = CMP_W'(cnt);
	assign in_range  = pos_c < cnt_c;
	assign ins_range = pos_c <= cnt_c;
	assign full      = cnt == CNT_W'(DEPTH);

	always_comb begin
		st_c   = pls_pkg::ST_OK;
		res_c  = '0;
		ins_ok = 1'b0;
		ers_ok = 1'b0;
		wr_ok  = 1'b0;
		case (op_s1)
			pls_pkg::OP_INSERT: begin
				if (!ins_range) begin
					st_c = pls_pkg::ST_RANGE;
				end else if (full) begin
					st_c = pls_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			pls_pkg::OP_READ: begin
				if (!in_range) begin
					st_c = pls_pkg::ST_RANGE;
				end else begin
					res_c = pls_pkg::VALUE_W'(rd_data);
				end
			end
			pls_pkg::OP_ERASE: begin
				if (!in_range) begin
					st_c = pls_pkg::ST_RANGE;
				end else begin
					res_c  = pls_pkg::VALUE_W'(rd_data);
					ers_ok = 1'b1;
				end
			end
			pls_pkg::OP_SET: begin
				if (!in_range) begin
					st_c = pls_pkg::ST_RANGE;
				end else begin
					wr_ok = 1'b1;
				end
			end
			default: begin
				st_c = pls_pkg::ST_RANGE;
			end
		endcase
	end

	always_comb begin
		if (ins_ok) begin
			cnt_nx = cnt + CNT_W'(1);
		end else if (ers_ok) begin
			cnt_nx = cnt - CNT_W'(1);
		end else begin
			cnt_nx = cnt;
		end
	end

	assign upd.ins = advance && ins_ok;
	assign upd.ers = advance && ers_ok;
	assign upd.wr  = advance && wr_ok;
	assign upd.pos = pos_s1;

	pls_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.word    (word_s1),
		.rd_data (rd_data),
		.cnt     (cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_value_s2 <= res_c;
			status_s2       <= st_c;
			count_s2        <= pls_pkg::COUNT_W'(cnt_nx);
		end
	end

	assign rsp_valid    = valid_s2;
	assign result_value = result_value_s2;
	assign status       = status_s2;
	assign count        = count_s2;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for positional_list_store: random and directed list requests
// over valid/ready, each result checked against an in-bench list predictor
// depends on pls_pkg and the positional_list_store rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_REQS = 670;
	localparam int QUIET_TAIL = 120;

	typedef struct {
		pls_pkg::op_t                op;
		logic [pls_pkg::POS_W-1:0]   pos;
		logic [pls_pkg::VALUE_W-1:0] word;
	} list_req_t;

	typedef struct {
		logic [pls_pkg::VALUE_W-1:0] word;
		pls_pkg::status_t            st;
		logic [pls_pkg::COUNT_W-1:0] fill;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [1:0] operation = '0;
	logic [pls_pkg::POS_W-1:0] position = '0;
	logic [pls_pkg::VALUE_W-1:0] value = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [pls_pkg::VALUE_W-1:0] result_value;
	logic [pls_pkg::STATUS_W-1:0] status;
	logic [pls_pkg::COUNT_W-1:0] count;

	list_req_t pending_reqs[$];
	list_reply_t replies_due[$];
	list_req_t cur_req;

	logic [pls_pkg::VALUE_W-1:0] model_words[LIST_DEPTH];
	int model_fill = 0;
	int gen_fill = 0;

	int total_reqs = 0;
	int sent_n = 0;
	int send_gap = 0;
	int stall_gap = 0;
	int errors = 0;
	logic hold_rsp = 1'b0;
	wire quiet = (sent_n >= total_reqs - QUIET_TAIL);

	positional_list_store #(
		.DEPTH(LIST_DEPTH),
		.DATA_WIDTH(pls_pkg::VALUE_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.operation(operation),
		.position(position),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.result_value(result_value),
		.status(status),
		.count(count)
	);

	always #5 clk = ~clk;

	// list behavior applied to one accepted request
	function automatic list_reply_t predict_list_op(list_req_t r);
		list_reply_t rep;
		int k;
		rep.word = '0;
		rep.st = pls_pkg::ST_OK;
		if (r.op == pls_pkg::OP_INSERT) begin
			if (int'(r.pos) > model_fill) begin
				rep.st = pls_pkg::ST_RANGE;
			end else if (model_fill >= LIST_DEPTH) begin
				rep.st = pls_pkg::ST_FULL;
			end else begin
				for (k = model_fill; k > int'(r.pos); k--)
					model_words[k] = model_words[k-1];
				model_words[r.pos] = r.word;
				model_fill++;
			end
		end else if (int'(r.pos) >= model_fill) begin
			rep.st = pls_pkg::ST_RANGE;
		end else if (r.op == pls_pkg::OP_READ) begin
			rep.word = model_words[r.pos];
		end else if (r.op == pls_pkg::OP_ERASE) begin
			rep.word = model_words[r.pos];
			for (k = int'(r.pos); k + 1 < model_fill; k++)
				model_words[k] = model_words[k+1];
			model_fill--;
		end else begin
			model_words[r.pos] = r.word;
		end
		rep.fill = pls_pkg::COUNT_W'(model_fill);
		return rep;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// queue a request and track the list size it leaves behind
	task automatic add_req(pls_pkg::op_t op, int pos, logic [pls_pkg::VALUE_W-1:0] word);
		list_req_t r;
		r.op = op;
		r.pos = pls_pkg::POS_W'(pos);
		r.word = word;
		pending_reqs.push_back(r);
		if (op == pls_pkg::OP_INSERT && pos <= gen_fill && gen_fill < LIST_DEPTH)
			gen_fill++;
		else if (op == pls_pkg::OP_ERASE && pos < gen_fill)
			gen_fill--;
	endtask

	function automatic logic [pls_pkg::VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic build_random(int n);
		int i;
		int r;
		int pos;
		bit grow;
		pls_pkg::op_t op;
		grow = 1'b1;
		for (i = 0; i < n; i++) begin
			if (gen_fill == 0)
				grow = 1'b1;
			else if (gen_fill >= LIST_DEPTH && $urandom_range(0, 3) == 0)
				grow = 1'b0;
			else if ($urandom_range(0, 39) == 0)
				grow = ~grow;
			r = $urandom_range(0, 99);
			if (grow)
				op = (r < 45) ? pls_pkg::OP_INSERT : (r < 60) ? pls_pkg::OP_ERASE :
					(r < 80) ? pls_pkg::OP_READ : pls_pkg::OP_SET;
			else
				op = (r < 45) ? pls_pkg::OP_ERASE : (r < 60) ? pls_pkg::OP_INSERT :
					(r < 80) ? pls_pkg::OP_READ : pls_pkg::OP_SET;
			r = $urandom_range(0, 9);
			if (r == 0)
				pos = $urandom_range(0, 31);
			else if (r <= 2)
				pos = 0;
			else if (r <= 4)
				pos = (op == pls_pkg::OP_INSERT || gen_fill == 0) ? gen_fill : gen_fill - 1;
			else if (op == pls_pkg::OP_INSERT)
				pos = $urandom_range(0, gen_fill);
			else
				pos = (gen_fill == 0) ? 0 : $urandom_range(0, gen_fill - 1);
			add_req(op, pos, pick_word());
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			operation <= '0;
			position <= '0;
			value <= '0;
			send_gap = 0;
		end else if (!req_valid || req_ready) begin
			if (req_valid) begin
				replies_due.push_back(predict_list_op(cur_req));
				sent_n <= sent_n + 1;
			end
			if (send_gap == 0 && !quiet && !hold_rsp && $urandom_range(0, 7) == 0)
				send_gap = $urandom_range(1, 18);
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				cur_req = pending_reqs.pop_front();
				operation <= cur_req.op;
				position <= cur_req.pos;
				value <= cur_req.word;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_gap = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: value %h status %0d count %0d",
						result_value, status, count));
				end else begin
					list_reply_t due;
					due = replies_due.pop_front();
					if (result_value !== due.word)
						report_mismatch($sformatf("result_value %h, expected %h",
							result_value, due.word));
					if (status !== due.st)
						report_mismatch($sformatf("status %0d, expected %0d", status, due.st));
					if (count !== due.fill)
						report_mismatch($sformatf("count %0d, expected %0d", count, due.fill));
				end
			end
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
			end else if (stall_gap > 0) begin
				stall_gap--;
				rsp_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_gap = $urandom_range(0, 17);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off so the pipeline backs up into the request side
	initial begin
		wait (arst_n);
		wait (sent_n >= 60);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (100) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin
		#3_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		int k;
		// empty list, out of range requests
		add_req(pls_pkg::OP_READ, 0, 32'h1111_1111);
		add_req(pls_pkg::OP_ERASE, 0, 32'h2222_2222);
		add_req(pls_pkg::OP_SET, 0, 32'h3333_3333);
		add_req(pls_pkg::OP_INSERT, 1, 32'h4444_4444);
		// front, back and middle
		add_req(pls_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
		add_req(pls_pkg::OP_INSERT, 0, 32'h0000_0000);
		add_req(pls_pkg::OP_INSERT, 2, 32'h1234_5678);
		add_req(pls_pkg::OP_READ, 1, 32'h0);
		add_req(pls_pkg::OP_SET, 2, 32'hDEAD_BEEF);
		add_req(pls_pkg::OP_READ, 3, 32'h0);
		add_req(pls_pkg::OP_ERASE, 1, 32'h0);
		add_req(pls_pkg::OP_ERASE, 1, 32'h0);
		// fill up, then full and range checks
		for (k = gen_fill; k < LIST_DEPTH; k++)
			add_req(pls_pkg::OP_INSERT, $urandom_range(0, gen_fill), $urandom);
		add_req(pls_pkg::OP_INSERT, 16, 32'h5555_5555);
		add_req(pls_pkg::OP_INSERT, 17, 32'h6666_6666);
		add_req(pls_pkg::OP_READ, 31, 32'h0);
		add_req(pls_pkg::OP_SET, 16, 32'h7777_7777);
		add_req(pls_pkg::OP_ERASE, 15, 32'h0);
		build_random(RANDOM_REQS);
		total_reqs = pending_reqs.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid || replies_due.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
